// ===== sv/scalar_kalman_filter_macros.svh =====
// Assertion macros for the scalar Kalman filter.
// Each expects clk and arst_n in the enclosing module.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SKF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/skf_pkg.sv =====
`default_nettype none

package skf_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned GAIN_W    = 17;
	localparam int unsigned COV_W     = 31;
	localparam int unsigned DIV_STEPS = 17;

	localparam logic [GAIN_W-1:0] Q_ONE   = 17'h10000;
	localparam logic [COV_W-1:0]  COV_MAX = 31'h7FFF_FFFF;

	localparam logic [COV_W-1:0]  RST_PROCESS_NOISE     = 31'd6554;
	localparam logic [COV_W-1:0]  RST_MEASUREMENT_NOISE = 31'd6554;
	localparam logic [31:0]       RST_INITIAL_ESTIMATE  = 32'd327680;
	localparam logic [COV_W-1:0]  RST_INITIAL_COV       = 31'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE     = 3'd0,
		REG_MEASUREMENT_NOISE = 3'd1,
		REG_INITIAL_ESTIMATE  = 3'd2,
		REG_INITIAL_COV       = 3'd3
	} cfg_reg_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic              done;
		logic [GAIN_W-1:0] quo;
	} div_res_t;

endpackage

`default_nettype wire

// ===== sv/skf_div.sv =====
`default_nettype none

// Restoring divider for the gain: quo = floor(num * 2^16 / den), num <= den.
// One quotient bit per cycle, MSB first; den of zero yields zero.
module skf_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [skf_pkg::COV_W-1:0]  num,
	input  wire logic [skf_pkg::COV_W:0]    den,
	output skf_pkg::div_res_t               res
);

	localparam int unsigned CNT_W = $clog2(skf_pkg::DIV_STEPS + 1);

	logic [CNT_W-1:0]              cnt_q;
	logic                          done_q;
	logic                          zero_q;
	logic [skf_pkg::COV_W+1:0]     rem_q;
	logic [skf_pkg::COV_W:0]       den_q;
	logic [skf_pkg::GAIN_W-1:0]    quo_q;

	logic [skf_pkg::COV_W+2:0]     diff;
	logic                          ge;
	logic [skf_pkg::COV_W+1:0]     rem_nxt;

	assign diff    = {1'b0, rem_q} - {2'b00, den_q};
	assign ge      = !diff[skf_pkg::COV_W+2];
	assign rem_nxt = ge ? diff[skf_pkg::COV_W+1:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(skf_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, 1'b0, num};
			den_q  <= den;
			quo_q  <= '0;
			zero_q <= (den == '0);
		end else if (cnt_q != '0) begin
			// remainder stays below den, so the shift fits
			rem_q <= {rem_nxt[skf_pkg::COV_W:0], 1'b0};
			quo_q <= {quo_q[skf_pkg::GAIN_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quo  = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire

// ===== sv/skf_mul.sv =====
`default_nettype none

// Registered signed multiplier shared by the estimate and covariance updates.
module skf_mul (
	input  wire logic               clk,
	input  wire logic signed [17:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [50:0]      prod
);

	logic signed [50:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ===== sv/scalar_kalman_filter.sv =====
// One-dimensional Kalman filter in signed Q16.16. Each measurement transfer
// runs the predict/update step: p1 = sat(p + q), gain k = p1 / (p1 + r),
// x += floor(k * (m - x)), p = floor((1 - k) * p1); one result transfer
// carries the new estimate, gain and covariance. Setting restart on a
// measurement reloads x and p from initial_estimate / initial_covariance
// before that step; register writes alone never touch the filter state.
// Each item runs from its accepting edge through a load state, a divider start
// state, the 17-step bit-per-cycle gain divider, the step that takes the gain,
// two passes through one registered 18x33 multiplier and the final update
// before its result shows on the output. in_stall stays high for that whole
// time and drops once the step is back in idle, so a measurement is taken
// only after the previous step is through. A result held by out_stall keeps
// the next step in its final state until the output register frees up; the
// output register lets a new measurement be taken while the previous result
// waits on out_stall.
`default_nettype none
`include "scalar_kalman_filter_macros.svh"

module scalar_kalman_filter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration writes
	input  wire logic                           wr_en,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [31:0]                    wr_data,
	// measurement channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [31:0]             measurement,
	input  wire logic                           restart,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [31:0]                  estimate,
	output logic [skf_pkg::GAIN_W-1:0]          gain,
	output logic [skf_pkg::COV_W-1:0]           covariance
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOAD = 7'b0000010,
		ST_DIVS = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_MULX = 7'b0010000,
		ST_MULP = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;

	// config registers
	logic [skf_pkg::COV_W-1:0]  q_q;
	logic [skf_pkg::COV_W-1:0]  r_q;
	logic [31:0]                x0_q;
	logic [skf_pkg::COV_W-1:0]  p0_q;

	// filter state
	logic signed [31:0]         x_q;
	logic [skf_pkg::COV_W-1:0]  p_q;

	// per-item working registers
	logic signed [31:0]         m_q;
	logic                       rst_q;
	logic [skf_pkg::COV_W-1:0]  p1_q;
	logic [skf_pkg::GAIN_W-1:0] k_q;
	logic signed [31:0]         xn_q;

	// output register
	logic                       out_valid_q;
	logic signed [31:0]         est_q;
	logic [skf_pkg::GAIN_W-1:0] gain_q;
	logic [skf_pkg::COV_W-1:0]  cov_q;

	logic                       in_xfer;
	logic                       out_free;

	logic signed [31:0]         x_sel;
	logic [skf_pkg::COV_W-1:0]  p_sel;
	logic [skf_pkg::COV_W:0]    p_sum;
	logic [skf_pkg::COV_W-1:0]  p1_nxt;

	logic                       div_start;
	logic [skf_pkg::COV_W:0]    div_den;
	skf_pkg::div_res_t          div_res;

	logic                       mul_cov;
	logic signed [17:0]         mul_a;
	logic signed [32:0]         mul_b;
	logic signed [50:0]         prod;
	logic signed [32:0]         innov;
	logic signed [34:0]         x_sum;
	logic signed [31:0]         x_sat;
	logic [skf_pkg::COV_W-1:0]  p_new;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// ---- predict: optional reload, then p1 = sat(p + q) ----
	assign x_sel  = rst_q ? $signed(x0_q) : x_q;
	assign p_sel  = rst_q ? p0_q : p_q;
	assign p_sum  = {1'b0, p_sel} + {1'b0, q_q};
	assign p1_nxt = p_sum[skf_pkg::COV_W] ? skf_pkg::COV_MAX : p_sum[skf_pkg::COV_W-1:0];

	// ---- gain: k = p1 * 2^16 / (p1 + r), den kept at full 32 bits ----
	assign div_start = (state_q == ST_DIVS);
	assign div_den   = {1'b0, p1_q} + {1'b0, r_q};

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p1_q),
		.den    (div_den),
		.res    (div_res)
	);

	// ---- shared multiplier: k*(m-x) first, then (1-k)*p1 ----
	// operands held through FIN so the covariance product stays put
	// while the result waits for the output register
	assign mul_cov = (state_q == ST_MULP) || (state_q == ST_FIN);
	assign innov   = {m_q[31], m_q} - {x_q[31], x_q};
	assign mul_a   = mul_cov ? $signed({1'b0, skf_pkg::Q_ONE - k_q})
	                         : $signed({1'b0, k_q});
	assign mul_b   = mul_cov ? $signed({2'b00, p1_q}) : innov;

	skf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// estimate: arithmetic shift is the floor; saturate to 32 bits
	assign x_sum = {{3{x_q[31]}}, x_q} + prod[50:16];
	always_comb begin
		priority if (!x_sum[34] && (x_sum[33:31] != 3'b000))
			x_sat = 32'sh7FFF_FFFF;
		else if (x_sum[34] && (x_sum[33:31] != 3'b111))
			x_sat = 32'sh8000_0000;
		else
			x_sat = x_sum[31:0];
	end

	// covariance product is nonnegative and at most p1 * 2^16
	assign p_new = (prod[50:47] != '0) ? skf_pkg::COV_MAX : prod[46:16];

	// ---- config registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q  <= skf_pkg::RST_PROCESS_NOISE;
			r_q  <= skf_pkg::RST_MEASUREMENT_NOISE;
			x0_q <= skf_pkg::RST_INITIAL_ESTIMATE;
			p0_q <= skf_pkg::RST_INITIAL_COV;
		end else if (wr_en) begin
			unique case (wr_index)
				skf_pkg::REG_PROCESS_NOISE:     q_q  <= wr_data[skf_pkg::COV_W-1:0];
				skf_pkg::REG_MEASUREMENT_NOISE: r_q  <= wr_data[skf_pkg::COV_W-1:0];
				skf_pkg::REG_INITIAL_ESTIMATE:  x0_q <= wr_data;
				skf_pkg::REG_INITIAL_COV:       p0_q <= wr_data[skf_pkg::COV_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- sequencer and filter state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= $signed(skf_pkg::RST_INITIAL_ESTIMATE);
			p_q         <= skf_pkg::RST_INITIAL_COV;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					x_q     <= x_sel;
					p_q     <= p_sel;
					state_q <= ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_res.done)
						state_q <= ST_MULX;
				end
				ST_MULX: state_q <= ST_MULP;
				ST_MULP: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						x_q         <= xn_q;
						p_q         <= p_new;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid: set when a step finishes, cleared on its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_q   <= measurement;
			rst_q <= restart;
		end
		if (state_q == ST_LOAD)
			p1_q <= p1_nxt;
		if ((state_q == ST_DIV) && div_res.done)
			k_q <= div_res.quo;
		if (state_q == ST_MULP)
			xn_q <= x_sat;
		if ((state_q == ST_FIN) && out_free) begin
			est_q  <= xn_q;
			gain_q <= k_q;
			cov_q  <= p_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign estimate   = est_q;
	assign gain       = gain_q;
	assign covariance = cov_q;

	// ---- checks ----
	`SKF_ASSERT_NEXT(a_accept_loads, in_xfer, state_q == ST_LOAD,
		"accepted measurement did not start a step")
	`SKF_ASSERT_NOW(a_div_done_in_div, div_res.done, state_q == ST_DIV,
		"divider finished outside the gain phase")
	`SKF_ASSERT_NOW(a_gain_range, (state_q == ST_MULX), k_q <= skf_pkg::Q_ONE,
		"gain above one")
	`SKF_ASSERT_NOW(a_cov_shrinks, (state_q == ST_FIN), p_new <= p1_q,
		"updated covariance exceeds predicted covariance")

endmodule

`default_nettype wire

// ===== tb/sv/tb_scalar_kalman_filter.sv =====
module tb_scalar_kalman_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 4;    // quiet time before a register write
	localparam int TAIL_CYCLES   = 30;   // past the block's item time, catches strays
	localparam int QUIET_LIMIT   = 1000; // cycles with no transfer or write at all
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 250;
	localparam int DRAIN_EVERY   = 100;
	localparam int CALM_PHASE    = 3;    // no idling on either side
	localparam int MAX_REPORTS   = 10;
	localparam int SMALL_SPAN    = 20 << 16; // +-20.0 in Q16.16
	localparam int IDX_W         = skf_pkg::CFG_IDX_W;

	localparam logic [31:0] EST_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] EST_MIN = 32'h8000_0000;
	localparam longint      Q_ONE_L   = longint'(skf_pkg::Q_ONE);
	localparam longint      COV_MAX_L = longint'(skf_pkg::COV_MAX);
	localparam logic [31:0] COV_MAX_W = {1'b0, skf_pkg::COV_MAX};

	// indexes past the last register; writes there must be dropped
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd4;

	typedef struct packed {
		logic signed [31:0]         est;
		logic [skf_pkg::GAIN_W-1:0] gn;
		logic [skf_pkg::COV_W-1:0]  cv;
	} filt_out_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	// one line of the directed sequence: either a register write or a
	// measurement, the latter with an optional hand-typed result
	typedef struct packed {
		row_kind_t            kind;
		logic [IDX_W-1:0]     index;
		logic [31:0]          value;
		logic                 restart;
		logic                 fixed;
		filt_out_t            typed;
	} plan_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        wr_en = 1'b0;
	logic [IDX_W-1:0]            wr_index = '0;
	logic [31:0]                 wr_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [31:0]          measurement = '0;
	logic                        restart = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [31:0]          estimate;
	logic [skf_pkg::GAIN_W-1:0]  gain;
	logic [skf_pkg::COV_W-1:0]   covariance;

	// side info that travels with the measurement payload
	logic                     typed_valid = 1'b0;
	filt_out_t                typed_result = '0;

	logic                     calm = 1'b0;
	int                       mismatches = 0;
	int                       results_seen = 0;
	int                       quiet = 0;

	filt_out_t                pending_results[$];
	plan_row_t                plan[$];

	// filter state and register copies kept by the checker
	longint x_state = longint'($signed(skf_pkg::RST_INITIAL_ESTIMATE));
	longint p_state = longint'(skf_pkg::RST_INITIAL_COV);
	longint q_cfg   = longint'(skf_pkg::RST_PROCESS_NOISE);
	longint r_cfg   = longint'(skf_pkg::RST_MEASUREMENT_NOISE);
	longint x0_cfg  = longint'($signed(skf_pkg::RST_INITIAL_ESTIMATE));
	longint p0_cfg  = longint'(skf_pkg::RST_INITIAL_COV);

	scalar_kalman_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.measurement(measurement),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.estimate   (estimate),
		.gain       (gain),
		.covariance (covariance)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One predict/update step on the checker's own state. All math in 64-bit
	// signed: p1 * 2^16 and k * (m - x) both stay well under 2^63.
	function automatic filt_out_t filter_step(input logic signed [31:0] m, input logic rst);
		longint    p1, den, k, xn, pn;
		filt_out_t res;
		if (rst) begin
			x_state = x0_cfg;
			p_state = p0_cfg;
		end
		p1 = p_state + q_cfg;
		if (p1 > COV_MAX_L)
			p1 = COV_MAX_L;
		den = p1 + r_cfg;
		// both zero: gain held at zero rather than dividing
		k = (den == 0) ? 0 : (p1 * Q_ONE_L) / den;
		if (k > Q_ONE_L)
			k = Q_ONE_L;
		// arithmetic shift of a signed value floors toward minus infinity
		xn = x_state + ((k * (longint'(m) - x_state)) >>> 16);
		if (xn > longint'($signed(EST_MAX)))
			xn = longint'($signed(EST_MAX));
		if (xn < longint'($signed(EST_MIN)))
			xn = longint'($signed(EST_MIN));
		pn = ((Q_ONE_L - k) * p1) >>> 16;
		if (pn > COV_MAX_L)
			pn = COV_MAX_L;
		x_state = xn;
		p_state = pn;
		res.est = xn[31:0];
		res.gn  = k[skf_pkg::GAIN_W-1:0];
		res.cv  = pn[skf_pkg::COV_W-1:0];
		return res;
	endfunction

	function automatic void plan_item(input logic [31:0] m, input logic rst);
		plan_row_t row = '0;
		row.kind    = ROW_ITEM;
		row.value   = m;
		row.restart = rst;
		plan.push_back(row);
	endfunction

	function automatic void plan_check(input logic [31:0] m, input logic rst,
			input logic [31:0] est, input logic [skf_pkg::GAIN_W-1:0] gn,
			input logic [skf_pkg::COV_W-1:0] cv);
		plan_row_t row = '0;
		row.kind     = ROW_ITEM;
		row.value    = m;
		row.restart  = rst;
		row.fixed    = 1'b1;
		row.typed.est = est;
		row.typed.gn  = gn;
		row.typed.cv  = cv;
		plan.push_back(row);
	endfunction

	function automatic void plan_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		plan_row_t row = '0;
		row.kind  = ROW_WRITE;
		row.index = idx;
		row.value = data;
		plan.push_back(row);
	endfunction

	function automatic logic [31:0] pick_measurement();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return EST_MAX;
					1: return EST_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2, 3, 4: return $urandom;
			default: return $urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN;
		endcase
	endfunction

	// noise / covariance word; bit 31 is random since the block masks it off
	function automatic logic [31:0] pick_noise();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = 1;
			2: v = COV_MAX_W;
			3, 4: v = $urandom_range(1, 1 << 20);
			default: v = $urandom;
		endcase
		v[31] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	function automatic logic [31:0] pick_estimate();
		case ($urandom_range(0, 5))
			0: return EST_MIN;
			1: return EST_MAX;
			2, 3: return $urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN;
			default: return $urandom;
		endcase
	endfunction

	// Register write, only called with the filter idle. The checker copy is
	// updated on the spot with the same masking the block applies.
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			skf_pkg::REG_PROCESS_NOISE:
				q_cfg  = longint'(data[skf_pkg::COV_W-1:0]);
			skf_pkg::REG_MEASUREMENT_NOISE:
				r_cfg  = longint'(data[skf_pkg::COV_W-1:0]);
			skf_pkg::REG_INITIAL_ESTIMATE:
				x0_cfg = longint'($signed(data));
			skf_pkg::REG_INITIAL_COV:
				p0_cfg = longint'(data[skf_pkg::COV_W-1:0]);
			default: ; // no such register
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_filter(input logic [31:0] q, input logic [31:0] r,
			input logic [31:0] x0, input logic [31:0] p0);
		cfg_write(skf_pkg::REG_PROCESS_NOISE, q);
		cfg_write(skf_pkg::REG_MEASUREMENT_NOISE, r);
		cfg_write(skf_pkg::REG_INITIAL_ESTIMATE, x0);
		cfg_write(skf_pkg::REG_INITIAL_COV, p0);
		cfg_write(REG_SPARE_LO + IDX_W'($urandom_range(0, 3)), $urandom);
	endtask

	// Sender holds off until every pending result is out. Queue size is read
	// on the falling edge so it never races the scoreboard.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Present one measurement and hold it until the transfer. Valid is not
	// dropped here unless an idle gap follows, so back-to-back items keep it
	// high with a single assignment per step.
	task automatic send(input logic [31:0] m, input logic rst, input logic fixed,
			input filt_out_t typed);
		in_valid     <= 1'b1;
		measurement  <= m;
		restart      <= rst;
		typed_valid  <= fixed;
		typed_result <= typed;
		do @(posedge clk); while (in_stall);
		// gap lengths up to past the item time so valid comes back at any
		// point of the block's work, not only under in_stall
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 28)) @(posedge clk);
		end
	endtask

	// Result side backpressure: rare stall bursts, mostly short, now and then
	// long enough that a finished result sits behind a new one.
	always @(posedge clk) begin : result_backpressure
		int stall_left;
		if (!arst_n || calm) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 99) < 2) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 6);
			out_stall  <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Checks the result transfer first, then books the measurement transfer
	// of the same edge, so ordering within the step cannot matter.
	always @(posedge clk) begin : scoreboard
		filt_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d with none pending: est %0d gain %0d cov %0d",
							results_seen, estimate, gain, covariance);
				end else begin
					want = pending_results.pop_front();
					if ({estimate, gain, covariance} !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result %0d: expected est %0d gain %0d cov %0d, got est %0d gain %0d cov %0d",
								results_seen, want.est, want.gn, want.cv,
								estimate, gain, covariance);
					end
				end
			end
			if (in_valid && !in_stall) begin
				// predictor always runs so its state tracks the block
				want = filter_step(measurement, restart);
				pending_results.push_back(typed_valid ? typed_result : want);
			end
		end
	end

	// Ends a hung run: no transfer and no write for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : stimulus
		plan_row_t row;

		// reset defaults, from scratch and through restart
		plan_item(32'd0, 1'b0);
		plan_item(EST_MAX, 1'b1);
		plan_item(EST_MIN, 1'b0);
		// zero measurement noise: gain is one, estimate jumps to the sample
		plan_write(skf_pkg::REG_MEASUREMENT_NOISE, 32'd0);
		plan_check(EST_MAX, 1'b0, EST_MAX, skf_pkg::Q_ONE, '0);
		plan_check(EST_MIN, 1'b0, EST_MIN, skf_pkg::Q_ONE, '0);
		plan_check(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, skf_pkg::Q_ONE, '0);
		// zero denominator: p + q and r all zero, gain zero, nothing moves
		plan_write(skf_pkg::REG_PROCESS_NOISE, 32'd0);
		plan_write(skf_pkg::REG_INITIAL_COV, 32'd0);
		plan_check(32'd12345, 1'b1, skf_pkg::RST_INITIAL_ESTIMATE, '0, '0);
		plan_check(EST_MIN, 1'b0, skf_pkg::RST_INITIAL_ESTIMATE, '0, '0);
		// covariance overflow: p + q saturates, full-scale estimate swing
		plan_write(skf_pkg::REG_PROCESS_NOISE, COV_MAX_W);
		plan_write(skf_pkg::REG_MEASUREMENT_NOISE, 32'd1);
		plan_write(skf_pkg::REG_INITIAL_ESTIMATE, EST_MIN);
		plan_write(skf_pkg::REG_INITIAL_COV, COV_MAX_W);
		plan_item(EST_MAX, 1'b1);
		plan_item(EST_MIN, 1'b0);
		// tiny gain, huge noise
		plan_write(skf_pkg::REG_PROCESS_NOISE, 32'd1);
		plan_write(skf_pkg::REG_MEASUREMENT_NOISE, COV_MAX_W);
		plan_write(skf_pkg::REG_INITIAL_ESTIMATE, EST_MAX);
		plan_write(skf_pkg::REG_INITIAL_COV, 32'd0);
		plan_item(EST_MIN, 1'b1);
		plan_item(EST_MAX, 1'b0);
		plan_item(32'd0, 1'b0);
		// stray index must be dropped; bit 31 of 31-bit registers is masked
		plan_write(REG_SPARE_LO, 32'hFFFF_FFFF);
		plan_write(skf_pkg::REG_PROCESS_NOISE, {1'b1, skf_pkg::RST_PROCESS_NOISE});
		plan_write(skf_pkg::REG_MEASUREMENT_NOISE, {1'b1, skf_pkg::RST_MEASUREMENT_NOISE});
		plan_write(skf_pkg::REG_INITIAL_ESTIMATE, skf_pkg::RST_INITIAL_ESTIMATE);
		plan_write(skf_pkg::REG_INITIAL_COV, {1'b1, skf_pkg::RST_INITIAL_COV});
		plan_item(32'd0, 1'b1);
		plan_item(32'd5 << 16, 1'b0);
		plan_item(-(32'd5 << 16), 1'b0);
		plan_item(32'h5555_5555, 1'b0);
		plan_item(32'hAAAA_AAAA, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				drain();
				cfg_write(row.index, row.value);
			end else begin
				send(row.value, row.restart, row.fixed, row.typed);
			end
		end

		// Random phases, each under its own register setting. The first two
		// pin the noise extremes; the calm phase runs with no idling at all.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			calm <= (ph == CALM_PHASE);
			case (ph)
				0: set_filter(COV_MAX_W, 32'd1, EST_MAX, COV_MAX_W);
				1: set_filter(32'd1, COV_MAX_W, EST_MIN, 32'd0);
				default: set_filter(pick_noise(), pick_noise(), pick_estimate(), pick_noise());
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n != 0 && n % DRAIN_EVERY == 0)
					drain();
				send(pick_measurement(), $urandom_range(0, 99) < 4, 1'b0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
